>>> src/almc_pkg.sv
// shared types and constants for the activity led mode controller
// no dependencies; imported by every module of the block
package almc_pkg;

    localparam int ELAPSED_W = 17;
    localparam int PERIOD_W  = 16;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_ON    = 3'd1,
        MODE_PULSE = 3'd2,
        MODE_HOLD  = 3'd3,
        MODE_BLINK = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        FN_TICK     = 3'd0,
        FN_SET_ON   = 3'd1,
        FN_SET_OFF  = 3'd2,
        FN_TRAFFIC  = 3'd3,
        FN_BLINK    = 3'd4,
        FN_RESTORE  = 3'd5
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_LEVEL = 2'd0,
        REG_INITIAL_MODE = 2'd1,
        REG_PULSE_ON_MS  = 2'd2,
        REG_HOLDOFF_MS   = 2'd3
    } reg_idx_t;

    // configuration seen by the state logic
    typedef struct packed {
        logic            active_level;
        logic [MS_W-1:0] pulse_on_ms;
        logic [MS_W-1:0] holdoff_ms;
        logic            load_mode;
        mode_t           load_value;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic  pin_level;
        mode_t mode;
    } result_t;

endpackage

>>> src/almc_cfg.sv
// configuration register file of the activity led mode controller
// depends on almc_pkg
module almc_cfg
    import almc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic            active_level_reg;
    logic [MS_W-1:0] pulse_on_ms_reg;
    logic [MS_W-1:0] holdoff_ms_reg;
    mode_t           mode_value;

    // out-of-range mode codes fall back to inactive
    always_comb
    begin
        if (cfg_data[2:0] > MODE_BLINK)
            mode_value = MODE_OFF;
        else
            mode_value = mode_t'(cfg_data[2:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= 1'b1;
            pulse_on_ms_reg  <= MS_W'(50);
            holdoff_ms_reg   <= MS_W'(50);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                REG_PULSE_ON_MS:  pulse_on_ms_reg  <= cfg_data[MS_W-1:0];
                REG_HOLDOFF_MS:   holdoff_ms_reg   <= cfg_data[MS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.active_level = active_level_reg;
        cfg.pulse_on_ms  = pulse_on_ms_reg;
        cfg.holdoff_ms   = holdoff_ms_reg;
        cfg.load_mode    = cfg_we && (reg_idx_t'(cfg_index) == REG_INITIAL_MODE);
        cfg.load_value   = mode_value;
    end

endmodule

>>> src/almc_state.sv
// mode state, elapsed timers and single-pass update logic
// depends on almc_pkg; driven by almc_cfg and the top level's input stage
module almc_state
    import almc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                step,
    input  func_t               func,
    input  logic [PERIOD_W-1:0] period,
    output result_t             result
);

    mode_t                cur_mode_reg, cur_mode_next;
    mode_t                saved_mode_reg, saved_mode_next;
    logic                 pin_reg, pin_next;
    logic [ELAPSED_W-1:0] pulse_elapsed_reg, pulse_elapsed_next;
    logic [ELAPSED_W-1:0] blink_elapsed_reg, blink_elapsed_next;
    logic [PERIOD_W-1:0]  period_now_reg, period_now_next;
    logic [PERIOD_W-1:0]  period_saved_reg, period_saved_next;
    logic [ELAPSED_W-1:0] pulse_bump, blink_bump;
    logic                 lit;

    always_comb
    begin
        lit = cfg.active_level;
        pulse_bump = (pulse_elapsed_reg == ELAPSED_MAX) ? ELAPSED_MAX
                   : pulse_elapsed_reg + ELAPSED_W'(1);
        blink_bump = (blink_elapsed_reg == ELAPSED_MAX) ? ELAPSED_MAX
                   : blink_elapsed_reg + ELAPSED_W'(1);

        cur_mode_next      = cur_mode_reg;
        saved_mode_next    = saved_mode_reg;
        pin_next           = pin_reg;
        pulse_elapsed_next = pulse_elapsed_reg;
        blink_elapsed_next = blink_elapsed_reg;
        period_now_next    = period_now_reg;
        period_saved_next  = period_saved_reg;

        if (step)
        begin
            case (func)
                FN_TICK:
                begin
                    pulse_elapsed_next = pulse_bump;
                    blink_elapsed_next = blink_bump;
                    case (cur_mode_reg)
                        MODE_OFF: pin_next = ~lit;
                        MODE_ON:  pin_next = lit;
                        MODE_PULSE:
                        begin
                            if (pulse_bump > {1'b0, cfg.pulse_on_ms})
                            begin
                                pin_next           = ~lit;
                                cur_mode_next      = MODE_HOLD;
                                pulse_elapsed_next = '0;
                            end
                        end
                        MODE_HOLD:
                        begin
                            if (pulse_bump > {1'b0, cfg.holdoff_ms})
                                cur_mode_next = saved_mode_reg;
                        end
                        MODE_BLINK:
                        begin
                            // half period threshold
                            if (blink_bump > {2'b00, period_now_reg[PERIOD_W-1:1]})
                            begin
                                pin_next           = ~pin_reg;
                                blink_elapsed_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                FN_SET_ON:
                begin
                    saved_mode_next = cur_mode_reg;
                    cur_mode_next   = MODE_ON;
                end
                FN_SET_OFF:
                begin
                    saved_mode_next = cur_mode_reg;
                    cur_mode_next   = MODE_OFF;
                end
                FN_TRAFFIC:
                begin
                    // ignored while a pulse or holdoff is running
                    if (cur_mode_reg != MODE_PULSE && cur_mode_reg != MODE_HOLD)
                    begin
                        pin_next           = lit;
                        saved_mode_next    = cur_mode_reg;
                        cur_mode_next      = MODE_PULSE;
                        pulse_elapsed_next = '0;
                    end
                end
                FN_BLINK:
                begin
                    saved_mode_next    = cur_mode_reg;
                    cur_mode_next      = MODE_BLINK;
                    period_saved_next  = period_now_reg;
                    period_now_next    = period;
                    blink_elapsed_next = '0;
                end
                FN_RESTORE:
                begin
                    cur_mode_next   = saved_mode_reg;
                    period_now_next = period_saved_reg;
                end
                default: ;
            endcase
        end

        if (cfg.load_mode)
        begin
            cur_mode_next   = cfg.load_value;
            saved_mode_next = cfg.load_value;
        end

        result.pin_level = pin_next;
        result.mode      = cur_mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode_reg      <= MODE_OFF;
            saved_mode_reg    <= MODE_OFF;
            pin_reg           <= 1'b0;
            pulse_elapsed_reg <= '0;
            blink_elapsed_reg <= '0;
            period_now_reg    <= '0;
            period_saved_reg  <= '0;
        end
        else
        begin
            cur_mode_reg      <= cur_mode_next;
            saved_mode_reg    <= saved_mode_next;
            pin_reg           <= pin_next;
            pulse_elapsed_reg <= pulse_elapsed_next;
            blink_elapsed_reg <= blink_elapsed_next;
            period_now_reg    <= period_now_next;
            period_saved_reg  <= period_saved_next;
        end
    end

`ifndef SYNTHESIS
    // traffic outside pulse/holdoff starts a fresh pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && func == FN_TRAFFIC && !cfg.load_mode
         && cur_mode_reg != MODE_PULSE && cur_mode_reg != MODE_HOLD)
        |=> (cur_mode_reg == MODE_PULSE && pulse_elapsed_reg == '0))
    else $error("traffic did not start a pulse");

    // blink start loads the period and restarts the blink timer
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && func == FN_BLINK && !cfg.load_mode)
        |=> (period_now_reg == $past(period) && blink_elapsed_reg == '0
             && cur_mode_reg == MODE_BLINK))
    else $error("blink start not applied");

    // pulse timer only counts up by one, saturates, or clears
    assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_elapsed_reg != $past(pulse_elapsed_reg))
        |-> (pulse_elapsed_reg == '0
             || pulse_elapsed_reg == $past(pulse_elapsed_reg) + ELAPSED_W'(1)))
    else $error("pulse timer jumped");
`endif

endmodule

>>> src/activity_led_mode_controller.sv
// activity led mode controller
// one led pin driven through inactive, active, pulse, holdoff and blink modes
// input channel s_axis: tuser carries the function code, tdata the blink
//   period (used by blink start only); every transfer is one input item
// output channel m_axis: one result transfer per input item, carrying the
//   pin level and the current mode after that item
// config port: cfg_we/cfg_index/cfg_data writes one register per cycle,
//   index 0 active level, 1 initial mode (also reloads both mode fields),
//   2 pulse on time, 3 holdoff time; write only while the block is idle
// pipeline: input register -> single-pass state update -> result register
//   result valid rises 1 cycle after the input transfer, so the earliest
//   result transfer comes 2 cycles after the input transfer
//   throughput is one item per cycle; the state update for an item happens
//   in the cycle it leaves the input register for the result register
// stall: when m_axis_tready is low and a result is waiting, the input
//   register holds one more item, then s_axis_tready drops
// reset (rst_n low, asynchronous): both channels empty, mode inactive,
//   pin dark, timers and periods zero, registers at their defaults
// depends on almc_pkg, almc_cfg and almc_state
module activity_led_mode_controller
    import almc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input item stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // [15:0] blink_period
    input  logic [2:0]            s_axis_tuser,  // [2:0] func
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata   // [0] pin_level, [3:1] mode, [7:4] zero
);

    cfg_t                cfg;
    result_t             result;

    // input stage
    logic                in_valid_reg;
    func_t               in_func_reg;
    logic [PERIOD_W-1:0] in_period_reg;

    // result stage
    logic                out_valid_reg;
    result_t             out_result_reg;

    logic                s_xfer;
    logic                advance;

    // an item moves on when the result register is empty or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    almc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    almc_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .func   (in_func_reg),
        .period (in_period_reg),
        .result (result)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_xfer)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_func_reg   <= func_t'(s_axis_tuser);
            in_period_reg <= s_axis_tdata;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // result payload, captured with the state update
    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_result_reg.mode, out_result_reg.pin_level};

endmodule
